### hdl/stt_pkg.sv
// Shared widths, register codes and stage payload types for the sub-tick timestamp timer.
package stt_pkg;

  localparam int unsigned CNT_W   = 24;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned CYC_W   = CNT_W + 1;
  localparam int unsigned IN_W    = 120;
  localparam int unsigned OUT_W   = 120;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_RELOAD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b1;

  localparam logic [CNT_W-1:0] RELOAD_RST = 24'd71999;

  // Timestamp after the counter step, plus the request's reference values.
  typedef struct packed {
    logic [TICK_W-1:0] now_ticks;
    logic [CYC_W-1:0]  now_cycles;
    logic [CYC_W-1:0]  period;
    logic [TICK_W-1:0] start_ticks;
    logic [CYC_W-1:0]  start_cycles;
    logic [TICK_W-1:0] dur_ticks;
    logic [CYC_W-1:0]  duration_cycles;
    logic              tick_event;
  } stamp_t;

  typedef struct packed {
    logic [TICK_W-1:0] now_ticks;
    logic [CYC_W-1:0]  now_cycles;
    logic [TICK_W-1:0] elapsed_ticks;
    logic [CYC_W-1:0]  elapsed_cycles;
    logic              expired;
    logic              tick_event;
  } result_t;

endpackage

### hdl/stt_counter.sv
// Reload down-counter, wrapping tick count, config registers and the timestamp stage register.
module stt_counter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [stt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stt_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic                          step,
  input  logic                          count_clock,
  input  logic [stt_pkg::TICK_W-1:0]    start_ticks,
  input  logic [stt_pkg::CYC_W-1:0]     start_cycles,
  input  logic [stt_pkg::TICK_W-1:0]    dur_ticks,
  input  logic [stt_pkg::CYC_W-1:0]     duration_cycles,
  output stt_pkg::stamp_t               stamp
);
  import stt_pkg::*;

  logic [CNT_W-1:0]  reload_r;
  logic              enable_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic              wrap;
  logic [CYC_W-1:0]  period;
  stamp_t            stamp_r, stamp_nxt;

  assign period = {1'b0, reload_r} + CYC_W'(1);

  always_comb begin
    cnt_nxt  = cnt_r;
    tick_nxt = tick_r;
    wrap     = 1'b0;
    if (enable_r && count_clock) begin
      if (cnt_r == '0) begin
        cnt_nxt  = reload_r;
        tick_nxt = tick_r + TICK_W'(1);
        wrap     = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_comb begin
    stamp_nxt.now_ticks       = tick_nxt;
    stamp_nxt.now_cycles      = period - {1'b0, cnt_nxt};
    stamp_nxt.period          = period;
    stamp_nxt.start_ticks     = start_ticks;
    stamp_nxt.start_cycles    = start_cycles;
    stamp_nxt.dur_ticks       = dur_ticks;
    stamp_nxt.duration_cycles = duration_cycles;
    stamp_nxt.tick_event      = wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= RELOAD_RST;
      enable_r <= 1'b0;
      cnt_r    <= '0;
      tick_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RELOAD: reload_r <= cfg_wdata;
          CFG_ENABLE: enable_r <= cfg_wdata[0];
          default:    ;
        endcase
      end
      if (step) begin
        cnt_r  <= cnt_nxt;
        tick_r <= tick_nxt;
      end
    end
  end

  // Payload only; validity is tracked by the top level.
  always_ff @(posedge clk) begin
    if (step) begin
      stamp_r <= stamp_nxt;
    end
  end

  assign stamp = stamp_r;

endmodule

### hdl/stt_elapsed.sv
// Elapsed-time borrow and expiry compare, feeding the result register.
module stt_elapsed (
  input  logic             clk,
  input  logic             load,
  input  stt_pkg::stamp_t  stamp,
  output stt_pkg::result_t result
);
  import stt_pkg::*;

  logic              borrow;
  logic [TICK_W-1:0] el_t;
  logic [CYC_W-1:0]  el_c;
  logic              late;
  result_t           result_r, result_nxt;

  assign borrow = stamp.now_cycles < stamp.start_cycles;

  always_comb begin
    el_t = stamp.now_ticks - stamp.start_ticks - TICK_W'(borrow);
    if (borrow) begin
      el_c = stamp.period - stamp.start_cycles + stamp.now_cycles;
    end else begin
      el_c = stamp.now_cycles - stamp.start_cycles;
    end
    late = (el_t > stamp.dur_ticks) ||
           ((el_t == stamp.dur_ticks) && (el_c >= stamp.duration_cycles));
  end

  always_comb begin
    result_nxt.now_ticks      = stamp.now_ticks;
    result_nxt.now_cycles     = stamp.now_cycles;
    result_nxt.elapsed_ticks  = el_t;
    result_nxt.elapsed_cycles = el_c;
    result_nxt.expired        = late;
    result_nxt.tick_event     = stamp.tick_event;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

### hdl/subtick_timestamp_timer.sv
// Top level of the sub-tick timestamp timer: stream handshake, stage valids and packing.
//
// Each request on the in_ stream is one clock step of the timer. If enable is set and
// count_clock is 1, the 24-bit down-counter steps; from zero it reloads and the 32-bit tick
// count advances. Every request yields exactly one result on the out_ stream: the current
// timestamp, the time elapsed since the request's start stamp, the expired flag and
// tick_event.
// A request taken at a clock edge is registered in the timestamp register, then moves into
// the result register when that one is free, which sets out_tvalid. Throughput is one
// request per cycle while out_tready is high; in_tready is high while the timestamp stage
// is empty or hands its entry on this cycle. When out_tready is low the results hold in place
// and in_tready drops once both stages are full; no request is lost or repeated.
// Configuration: cfg_index 0 writes reload (tick period is reload + 1), index 1 writes
// enable (bit 0). Write only while no request is in flight.
// Reset (rst_n low, synchronous) clears the counter and tick count, sets reload to 71999,
// clears enable and empties the pipeline.
module subtick_timestamp_timer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [stt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stt_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [0] count_clock, [32:1] start_ticks, [57:33] start_cycles,
  // [89:58] dur_ticks, [114:90] duration_cycles, [119:115] zero
  input  logic [stt_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [31:0] now_ticks, [56:32] now_cycles, [88:57] elapsed_ticks,
  // [113:89] elapsed_cycles, [114] expired, [115] tick_event, [119:116] zero
  output logic [stt_pkg::OUT_W-1:0]     out_tdata
);
  import stt_pkg::*;

  logic    s1_v_r;
  logic    out_v_r;
  logic    out_free;
  logic    s1_free;
  logic    take;
  logic    move;
  stamp_t  stamp;
  result_t result;

  assign out_free  = !out_v_r || out_tready;
  assign move      = s1_v_r && out_free;
  assign s1_free   = !s1_v_r || out_free;
  assign in_tready = s1_free;
  assign take      = in_tvalid && s1_free;

  stt_counter u_counter (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .step            (take),
    .count_clock     (in_tdata[0]),
    .start_ticks     (in_tdata[32:1]),
    .start_cycles    (in_tdata[57:33]),
    .dur_ticks       (in_tdata[89:58]),
    .duration_cycles (in_tdata[114:90]),
    .stamp           (stamp)
  );

  stt_elapsed u_elapsed (
    .clk    (clk),
    .load   (move),
    .stamp  (stamp),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_r <= take;
      end
      if (out_free) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0000, result.tick_event, result.expired, result.elapsed_cycles,
                       result.elapsed_ticks, result.now_cycles, result.now_ticks};

endmodule

### bench/tb_subtick_timestamp_timer.sv
// Self-checking bench for the sub-tick timestamp timer: stream stimulus, prediction, result check.
`timescale 1ns / 1ps

module tb_subtick_timestamp_timer;
  import stt_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 64;
  localparam int SETTLE_CYCLES = 4;
  localparam int NUM_PHASES = 8;
  localparam logic [CYC_W-1:0] CYC_MAX = 25'h1000000;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE} rx_style_t;

  typedef struct {
    logic              count_clock;
    logic [TICK_W-1:0] start_ticks;
    logic [CYC_W-1:0]  start_cycles;
    logic [TICK_W-1:0] dur_ticks;
    logic [CYC_W-1:0]  duration_cycles;
  } req_t;

  // Running copy of the timer; one expected stamp per accepted request.
  class timer_scoreboard;
    logic [CNT_W-1:0]  reload_val;
    logic              run_en;
    logic [CNT_W-1:0]  down_cnt;
    logic [TICK_W-1:0] tick_cnt;
    result_t           expected_stamps[$];
    int                errors;
    int                n_req;
    int                n_tick_ev;
    int                n_expired;

    function new();
      reload_val = RELOAD_RST;
      run_en     = 1'b0;
      down_cnt   = '0;
      tick_cnt   = '0;
      errors     = 0;
      n_req      = 0;
      n_tick_ev  = 0;
      n_expired  = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
      if (idx == CFG_RELOAD) reload_val = data;
      else if (idx == CFG_ENABLE) run_en = data[0];
    endfunction

    function int pending();
      return expected_stamps.size();
    endfunction

    function void note_request(req_t r);
      result_t e;
      logic [CYC_W-1:0] period;
      period = {1'b0, reload_val} + 25'd1;
      e.tick_event = 1'b0;
      if (run_en && r.count_clock) begin
        if (down_cnt == '0) begin
          down_cnt = reload_val;
          tick_cnt = tick_cnt + 32'd1;
          e.tick_event = 1'b1;
        end else begin
          down_cnt = down_cnt - 24'd1;
        end
      end
      e.now_ticks = tick_cnt;
      e.now_cycles = period - {1'b0, down_cnt};
      e.elapsed_ticks = tick_cnt - r.start_ticks;
      if (e.now_cycles >= r.start_cycles) begin
        e.elapsed_cycles = e.now_cycles - r.start_cycles;
      end else begin
        // borrow one whole tick period
        e.elapsed_ticks = e.elapsed_ticks - 32'd1;
        e.elapsed_cycles = period - r.start_cycles + e.now_cycles;
      end
      e.expired = (e.elapsed_ticks > r.dur_ticks) ||
                  (e.elapsed_ticks == r.dur_ticks &&
                   e.elapsed_cycles >= r.duration_cycles);
      expected_stamps.push_back(e);
      n_req++;
      if (e.tick_event) n_tick_ev++;
      if (e.expired) n_expired++;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] d);
      result_t want;
      result_t got;
      got.now_ticks      = d[31:0];
      got.now_cycles     = d[56:32];
      got.elapsed_ticks  = d[88:57];
      got.elapsed_cycles = d[113:89];
      got.expired        = d[114];
      got.tick_event     = d[115];
      if (expected_stamps.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, expected none, got %h", $time, d);
        return;
      end
      want = expected_stamps.pop_front();
      compare_field("now_ticks", want.now_ticks, got.now_ticks);
      compare_field("now_cycles", 32'(want.now_cycles), 32'(got.now_cycles));
      compare_field("elapsed_ticks", want.elapsed_ticks, got.elapsed_ticks);
      compare_field("elapsed_cycles", 32'(want.elapsed_cycles), 32'(got.elapsed_cycles));
      compare_field("expired", 32'(want.expired), 32'(got.expired));
      compare_field("tick_event", 32'(want.tick_event), 32'(got.tick_event));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;

  logic      hold_go;
  logic      hold_go_q;
  int        hold_cnt;
  rx_style_t rx_style;
  int        quiet_cycles;

  timer_scoreboard timer_sb;

  // per phase: reload range, enable, request count, receiver style, sender gaps, hold-off
  int unsigned ph_rl_lo [NUM_PHASES] = '{1, 5, 0, 20, 2, 9, 16777215, 2};
  int unsigned ph_rl_hi [NUM_PHASES] = '{1, 5, 0, 120, 40, 9, 16777215, 2};
  bit          ph_en    [NUM_PHASES] = '{1, 1, 1, 1, 1, 0, 1, 1};
  int          ph_items [NUM_PHASES] = '{110, 150, 70, 120, 170, 50, 100, 70};
  rx_style_t   ph_rx    [NUM_PHASES] = '{RX_ALWAYS, RX_COIN, RX_SPARSE, RX_SPARSE,
                                         RX_COIN, RX_SPARSE, RX_COIN, RX_ALWAYS};
  bit          ph_gaps  [NUM_PHASES] = '{0, 0, 1, 1, 1, 1, 1, 1};
  bit          ph_hold  [NUM_PHASES] = '{0, 1, 0, 0, 0, 0, 0, 0};

  subtick_timestamp_timer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: a long hold-off on request, otherwise the phase's stall pattern.
  always @(posedge clk) begin
    hold_go_q <= hold_go;
    if (hold_go && !hold_go_q) hold_cnt = HOLD_CYCLES;
    if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt = hold_cnt - 1;
    end else begin
      case (rx_style)
        RX_ALWAYS: out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        default:   out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) timer_sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(input logic cc, input logic [TICK_W-1:0] st_t,
                           input logic [CYC_W-1:0] st_c, input logic [TICK_W-1:0] du_t,
                           input logic [CYC_W-1:0] du_c);
    req_t r;
    r.count_clock     = cc;
    r.start_ticks     = st_t;
    r.start_cycles    = st_c;
    r.dur_ticks       = du_t;
    r.duration_cycles = du_c;
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, du_c, du_t, st_c, st_t, cc};
    do @(posedge clk); while (!in_tready);
    timer_sb.note_request(r);
  endtask

  // Write one register, then drop cfg_we and idle before anything else.
  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    timer_sb.apply_reg(idx, data);
    @(posedge clk);
  endtask

  // Stop offering, let every pending result drain, then settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (timer_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [TICK_W-1:0] st_t;
    logic [TICK_W-1:0] du_t;
    logic [CYC_W-1:0]  st_c;
    logic [CYC_W-1:0]  du_c;
    logic [CYC_W-1:0]  per;
    logic [22:0]       junk;
    logic              cc;
    int                pick;
    int                burst_left;
    int                n_cfg;

    timer_sb   = new();
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_RELOAD;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    hold_go    <= 1'b0;
    rx_style   <= RX_ALWAYS;
    burst_left = 0;
    n_cfg      = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset: timer disabled, default reload; count clocks must be ignored.
    send_item(1'b0, 32'h0, 25'd1, 32'h0, 25'd0);
    send_item(1'b1, 32'h0, 25'd72000, 32'h0, 25'd0);
    send_item(1'b1, 32'h0, CYC_MAX, 32'hFFFF_FFFF, CYC_MAX);
    send_item(1'b0, 32'hFFFF_FFFF, 25'd1, 32'hFFFF_FFFF, 25'd0);
    send_item(1'b1, 32'h5555_5555, 25'h0AA_AAAA, 32'hAAAA_AAAA, 25'h055_5555);
    drain();

    // First counted clock loads the counter from zero and bumps the tick count.
    program_reg(CFG_RELOAD, 24'd3);
    program_reg(CFG_ENABLE, 24'd1);
    n_cfg++;
    send_item(1'b1, 32'h0, 25'd1, 32'h0, 25'd0);
    for (int i = 0; i < 4; i++) send_item(1'b1, 32'd1, 25'd1, 32'd1, 25'(i));
    send_item(1'b0, 32'd1, 25'd4, 32'd0, 25'd4);
    send_item(1'b1, 32'hFFFF_FFFF, CYC_MAX, 32'hFFFF_FFFF, CYC_MAX);
    send_item(1'b1, 32'd2, 25'd3, 32'd0, 25'd1);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      junk = 23'($urandom);
      program_reg(CFG_RELOAD, 24'($urandom_range(ph_rl_lo[p], ph_rl_hi[p])));
      program_reg(CFG_ENABLE, ($urandom_range(0, 1) ? {junk, ph_en[p]} : {23'b0, ph_en[p]}));
      n_cfg++;
      rx_style <= ph_rx[p];
      hold_go  <= ph_hold[p];
      for (int i = 0; i < ph_items[p]; i++) begin
        if (ph_gaps[p]) begin
          if (burst_left == 0) begin
            in_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
          end else begin
            burst_left--;
          end
        end
        per  = {1'b0, timer_sb.reload_val} + 25'd1;
        cc   = ($urandom_range(0, 4) != 0);
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          // start a few ticks back so the expiry flag goes both ways
          st_t = timer_sb.tick_cnt - $urandom_range(0, 3);
          st_c = 25'($urandom_range(1, per));
          du_t = $urandom_range(0, 3);
          du_c = 25'($urandom_range(0, per));
        end else if (pick < 9) begin
          st_t = $urandom;
          st_c = 25'($urandom_range(1, CYC_MAX));
          du_t = $urandom;
          du_c = 25'($urandom_range(0, CYC_MAX));
        end else begin
          st_t = timer_sb.tick_cnt + 32'd1;
          st_c = $urandom_range(0, 1) ? 25'd1 : CYC_MAX;
          du_t = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
          du_c = $urandom_range(0, 1) ? 25'd0 : CYC_MAX;
        end
        send_item(cc, st_t, st_c, du_t, du_c);
      end
      drain();
      hold_go <= 1'b0;
    end

    $display("covered %0d requests across %0d timer settings", timer_sb.n_req, n_cfg);
    $display("saw %0d tick events and %0d expired stamps, %0d mismatches",
             timer_sb.n_tick_ev, timer_sb.n_expired, timer_sb.errors);
    if (timer_sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
